// ----- src/nearest_centroid_quantizer_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the nearest-centroid quantizer
// Shorthand for clocked implications, with the reset as the disable condition.
// ----------------------------------------------------------------------------
`ifndef NEAREST_CENTROID_QUANTIZER_CORE_MACROS_SVH
`define NEAREST_CENTROID_QUANTIZER_CORE_MACROS_SVH

// The consequent must hold at the same edge as the antecedent.
`define NCQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold at the edge after the antecedent.
`define NCQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ncq_pkg.sv -----
// ----------------------------------------------------------------------------
// ncq_pkg
// Field widths, operation codes and register indexes of the quantizer.
// ----------------------------------------------------------------------------
package ncq_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int ACC_W       = 40;
    localparam int SQ_W        = 32;
    localparam int CLASS_W     = 4;
    localparam int CSEL_W      = 4;
    localparam int DSEL_W      = 5;
    localparam int CCOUNT_W    = 5;
    localparam int VLEN_W      = 6;
    localparam int CFG_DATA_W  = 6;
    localparam int CFG_INDEX_W = 1;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_CENTROID_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_VECTOR_LENGTH  = 1'b1;

    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 5'd15;
    localparam logic [VLEN_W-1:0]   VLEN_RESET   = 6'd19;

endpackage

// ----- src/nearest_centroid_quantizer_core.sv -----
// A load word, or a feature element that neither adds nor closes a vector, is
// done in the cycle it is accepted; any other feature word starts a sweep over the
// centroids in use through RUN and DRAIN, and the final word of a vector then has
// its result put in the output register from POST. No new word is taken until the
// sweep is over, and POST waits while an earlier result is stalled.
// Reset clears the control state, the output valid and all accumulator valid bits at once.
// ----------------------------------------------------------------------------
// nearest_centroid_quantizer_core
// Nearest-centroid vector quantizer with squared Euclidean distance.
// ----------------------------------------------------------------------------
module nearest_centroid_quantizer_core #(
    parameter int MAX_CENTROIDS = 16,
    parameter int MAX_DIMS      = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port.
    input  logic                                  cfg_we,
    input  logic [ncq_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ncq_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic                                  op,
    input  logic [ncq_pkg::CSEL_W-1:0]            centroid_sel,
    input  logic [ncq_pkg::DSEL_W-1:0]            dim_sel,
    input  logic signed [ncq_pkg::SAMPLE_W-1:0]   sample_value,
    input  logic                                  last_element,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [ncq_pkg::CLASS_W-1:0]           class_index,
    output logic [ncq_pkg::ACC_W-1:0]             min_distance
);
    import ncq_pkg::*;

    // Index widths follow from the table dimensions.
    localparam int CW    = $clog2(MAX_CENTROIDS);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH = MAX_CENTROIDS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);

    // The sequencer walks the centroids in use for one feature word. RUN issues
    // one memory read a cycle, DRAIN waits for the three-stage update pipeline to
    // write back its last sum, and POST hands the result to the output register.
    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_POST
    } state_t;

    state_t                 state_reg;
    logic [CCOUNT_W-1:0]    centroid_count_reg;
    logic [VLEN_W-1:0]      vector_length_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   last_reg;
    logic                   add_en_reg;
    logic                   p1_v_reg;
    logic                   p2_v_reg;
    logic                   p3_v_reg;
    logic                   p1_accv_reg;
    logic [MAX_CENTROIDS-1:0] acc_valid_reg;
    logic [CW-1:0]          best_idx_reg;
    logic [ACC_W-1:0]       best_sum_reg;
    logic                   out_valid_reg;
    logic [CLASS_W-1:0]     class_index_reg;
    logic [ACC_W-1:0]       min_distance_reg;

    // Datapath registers; they carry payload only and need no reset.
    logic [SAMPLE_W-1:0]    x_reg;
    logic [DW-1:0]          dim_reg;
    logic [CW-1:0]          p1_idx_reg;
    logic [CW-1:0]          p2_idx_reg;
    logic [CW-1:0]          p3_idx_reg;
    logic signed [SAMPLE_W:0] diff_reg;
    logic [ACC_W-1:0]       p2_acc_reg;
    logic [SQ_W-1:0]        sq_reg;
    logic [ACC_W-1:0]       p3_acc_reg;

    // Memories and their registered read data.
    logic [SAMPLE_W-1:0]    cent_mem [DEPTH];
    logic [SAMPLE_W-1:0]    cent_rd_reg;
    logic [ACC_W-1:0]       acc_mem [MAX_CENTROIDS];
    logic [ACC_W-1:0]       acc_rd_reg;

    logic                   in_acc;
    logic                   load_ok;
    logic                   add_ok;
    logic                   load_go;
    logic                   feat_go;
    logic [AW-1:0]          cent_waddr;
    logic [AW-1:0]          cent_raddr;
    logic [CW-1:0]          last_idx;
    logic signed [SAMPLE_W:0] diff;
    logic [ACC_W-1:0]       acc_in;
    logic [SAMPLE_W:0]      neg_diff;
    logic [SAMPLE_W-1:0]    abs_diff;
    logic [SQ_W-1:0]        sq;
    logic [ACC_W:0]         sum_wide;
    logic [ACC_W-1:0]       new_sum;
    logic                   take_best;

    // The block takes a word only when the sequencer is idle. Load words finish
    // in the cycle they are accepted; feature words hold the input for the sweep.
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    // Loads beyond the table are dropped. A feature element beyond the vector
    // length adds nothing, but a last mark on it still closes the vector.
    assign load_ok = (int'(centroid_sel) < MAX_CENTROIDS) && (int'(dim_sel) < MAX_DIMS);
    assign add_ok  = ({1'b0, dim_sel} < vector_length_reg) && (int'(dim_sel) < MAX_DIMS);
    assign load_go = in_acc && (op == OP_LOAD) && load_ok;
    assign feat_go = in_acc && (op == OP_FEATURE) && (add_ok || last_element);

    // A centroid count of zero searches one centroid, and counts above the table
    // size saturate to the table size.
    always_comb
    begin
        if (centroid_count_reg == '0)
        begin
            last_idx = '0;
        end
        else if (int'(centroid_count_reg) >= MAX_CENTROIDS)
        begin
            last_idx = CW'(MAX_CENTROIDS - 1);
        end
        else
        begin
            last_idx = CW'(centroid_count_reg - 1'b1);
        end
    end

    // Centroid c occupies a row of MAX_DIMS entries.
    assign cent_waddr = AW'(centroid_sel) * AW'(MAX_DIMS) + AW'(dim_sel);
    assign cent_raddr = AW'(cnt_reg) * AW'(MAX_DIMS) + AW'(dim_reg);

    // Stage one: read data is back; form the signed difference. An accumulator
    // whose valid bit is clear reads as zero.
    assign diff   = $signed({x_reg[SAMPLE_W-1], x_reg})
                  - $signed({cent_rd_reg[SAMPLE_W-1], cent_rd_reg});
    assign acc_in = p1_accv_reg ? acc_rd_reg : '0;

    // Stage two: square the magnitude. The difference of two Q8.8 values stays
    // below 2^16 in magnitude, so the square is exact in 32 bits.
    assign neg_diff = -diff_reg;
    assign abs_diff = diff_reg[SAMPLE_W] ? neg_diff[SAMPLE_W-1:0] : diff_reg[SAMPLE_W-1:0];
    assign sq       = add_en_reg ? (SQ_W'(abs_diff) * SQ_W'(abs_diff)) : '0;

    // Stage three: saturating add and write back, and the running minimum.
    // The strict compare keeps the lowest index on a tie.
    assign sum_wide  = {1'b0, p3_acc_reg} + (ACC_W + 1)'(sq_reg);
    assign new_sum   = sum_wide[ACC_W] ? '1 : sum_wide[ACC_W-1:0];
    assign take_best = (p3_idx_reg == '0) || (new_sum < best_sum_reg);

    // Centroid table: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (load_go)
        begin
            cent_mem[cent_waddr] <= sample_value;
        end
        cent_rd_reg <= cent_mem[cent_raddr];
    end

    // Accumulator memory. Reads and writes of the same entry never overlap: one
    // sweep touches each centroid once, and the next word waits for the drain.
    always_ff @(posedge clk)
    begin
        if (p3_v_reg)
        begin
            acc_mem[p3_idx_reg] <= new_sum;
        end
        acc_rd_reg <= acc_mem[cnt_reg];
    end

    // Datapath pipeline registers.
    always_ff @(posedge clk)
    begin
        if (feat_go)
        begin
            x_reg   <= sample_value;
            dim_reg <= DW'(dim_sel);
        end
        p1_idx_reg <= cnt_reg;
        diff_reg   <= diff;
        p2_acc_reg <= acc_in;
        p2_idx_reg <= p1_idx_reg;
        sq_reg     <= sq;
        p3_acc_reg <= p2_acc_reg;
        p3_idx_reg <= p2_idx_reg;
    end

    // Sequencer, configuration, valid bits and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            centroid_count_reg <= CCOUNT_RESET;
            vector_length_reg  <= VLEN_RESET;
            cnt_reg            <= '0;
            last_reg           <= 1'b0;
            add_en_reg         <= 1'b0;
            p1_v_reg           <= 1'b0;
            p2_v_reg           <= 1'b0;
            p3_v_reg           <= 1'b0;
            p1_accv_reg        <= 1'b0;
            acc_valid_reg      <= '0;
            best_idx_reg       <= '0;
            best_sum_reg       <= '0;
            out_valid_reg      <= 1'b0;
            class_index_reg    <= '0;
            min_distance_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTROID_COUNT: centroid_count_reg <= cfg_data[CCOUNT_W-1:0];
                    REG_VECTOR_LENGTH:  vector_length_reg  <= cfg_data[VLEN_W-1:0];
                    default:            ;
                endcase
            end

            p1_v_reg    <= (state_reg == S_RUN);
            p1_accv_reg <= acc_valid_reg[cnt_reg];
            p2_v_reg    <= p1_v_reg;
            p3_v_reg    <= p2_v_reg;

            if (p3_v_reg)
            begin
                acc_valid_reg[p3_idx_reg] <= 1'b1;
                if (take_best)
                begin
                    best_idx_reg <= p3_idx_reg;
                    best_sum_reg <= new_sum;
                end
            end

            // In POST the hand-over below drives the output valid itself.
            if (out_valid_reg && !out_stall && (state_reg != S_POST))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (feat_go)
                    begin
                        cnt_reg    <= '0;
                        last_reg   <= last_element;
                        add_en_reg <= add_ok;
                        state_reg  <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    if (cnt_reg == last_idx)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // All sums are written back once the pipeline is empty.
                    if (!p1_v_reg && !p2_v_reg && !p3_v_reg)
                    begin
                        cnt_reg <= '0;
                        if (last_reg)
                        begin
                            acc_valid_reg <= '0;
                            state_reg     <= S_POST;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_POST:
                begin
                    // Wait for the output register to free up before handing over.
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg    <= 1'b1;
                        class_index_reg  <= CLASS_W'(best_idx_reg);
                        min_distance_reg <= best_sum_reg;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid    = out_valid_reg;
    assign class_index  = class_index_reg;
    assign min_distance = min_distance_reg;

endmodule

// ----- src/ncq_checker.sv -----
// ----------------------------------------------------------------------------
// ncq_checker
// Port-level checks for the nearest-centroid quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "nearest_centroid_quantizer_core_macros.svh"

module ncq_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic                         op,
    input  logic                         last_element,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ncq_pkg::CLASS_W-1:0]  class_index,
    input  logic [ncq_pkg::ACC_W-1:0]    min_distance
);
    import ncq_pkg::*;

    // A stalled result word stays offered and unchanged.
    `NCQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")
    `NCQ_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(class_index) && $stable(min_distance), "result word changed while stalled")

    // A centroid load never produces a result word.
    `NCQ_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && (op == OP_LOAD), !$rose(out_valid), "load word produced a result")

    // The final element of a vector always starts a sweep, so the input stalls.
    `NCQ_ASSERT_NEXT(a_last_sweeps, in_valid && !in_stall && (op == OP_FEATURE) && last_element, in_stall, "final element did not start a sweep")

endmodule

bind nearest_centroid_quantizer_core ncq_checker u_ncq_checker (.*);

// ----- tb/sv/tb_nearest_centroid_quantizer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nearest_centroid_quantizer_core
// Self-checking bench for the nearest-centroid quantizer. A directed table walks
// the value extremes and the corner cases. A saturating long vector follows, and
// then random phases over several register settings. Every result word is
// compared with a bit-accurate classifier kept inside the bench.
// ----------------------------------------------------------------------------
module tb_nearest_centroid_quantizer_core;

    import ncq_pkg::*;

    localparam int CENTROIDS     = 16;
    localparam int DIMS          = 32;
    // The slowest feature word sweeps all sixteen centroids, and this wait
    // is comfortably past the longest time the core can stay busy.
    localparam int SETTLE_CYCLES = 32;
    localparam int RANDOM_WORDS  = 250;
    localparam int PHASE_WORDS   = 25;
    localparam int OVERFLOW_RUN  = 300;
    localparam int IDLE_PCT      = 59;
    localparam int BOTH_PCT      = 22;
    localparam longint TIMEOUT_NS = 4_000_000;

    localparam logic signed [SAMPLE_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] Q_MIN = 16'sh8000;
    localparam logic [ACC_W-1:0] ACC_FULL     = {ACC_W{1'b1}};
    localparam logic [ACC_W-1:0] SQ_OF_Q_MAX  = 40'h00_3FFF_0001;
    localparam logic [ACC_W-1:0] SQ_OF_Q_MIN  = 40'h00_4000_0000;

    typedef struct packed {
        logic                       op;
        logic [CSEL_W-1:0]          csel;
        logic [DSEL_W-1:0]          dsel;
        logic signed [SAMPLE_W-1:0] value;
        logic                       last;
    } word_t;

    typedef struct packed {
        logic [CLASS_W-1:0] cls;
        logic [ACC_W-1:0]   distance;
    } verdict_t;

    typedef enum logic {ROW_WORD, ROW_REGISTER} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        word_t                  word;
        logic [CFG_INDEX_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0]  reg_data;
        logic                   typed;
        verdict_t               verdict;
    } stimulus_row_t;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    // Clock, reset and every input of the core start from a known value.
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_we       = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index    = '0;
    logic [CFG_DATA_W-1:0]      cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic                       op           = OP_LOAD;
    logic [CSEL_W-1:0]          centroid_sel = '0;
    logic [DSEL_W-1:0]          dim_sel      = '0;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                       last_element = 1'b0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic [CLASS_W-1:0]         class_index;
    logic [ACC_W-1:0]           min_distance;

    // Classifier state: the bench's own copy of the centroid table, the running
    // distance sums and the two registers.
    logic signed [SAMPLE_W-1:0] codebook [CENTROIDS][DIMS];
    logic [ACC_W-1:0]           running_sums [CENTROIDS];
    logic [CCOUNT_W-1:0]        count_reg = CCOUNT_RESET;
    logic [VLEN_W-1:0]          length_reg = VLEN_RESET;

    // Class and distance of every closed vector, oldest first.
    verdict_t      pending_classes [$];
    stimulus_row_t directed_rows [$];

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int words_sent         = 0;
    int vectors_closed     = 0;
    int results_checked    = 0;
    int mismatch_count     = 0;
    int settings_applied   = 0;

    nearest_centroid_quantizer_core #(
        .MAX_CENTROIDS (CENTROIDS),
        .MAX_DIMS      (DIMS)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .centroid_sel (centroid_sel),
        .dim_sel      (dim_sel),
        .sample_value (sample_value),
        .last_element (last_element),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .class_index  (class_index),
        .min_distance (min_distance)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Runs one word through the classifier. A load only writes the table. A
    // feature element adds its squared difference to the sum of every centroid in
    // use, unless its position is past the vector length. The last mark closes
    // the vector: the lowest sum wins, the lowest index on a tie, and all sums
    // start over from zero.
    function automatic void classify_word(input word_t w, output logic emits,
                                          output verdict_t result);
        int unsigned         n;
        int unsigned         best;
        longint              d;
        longint              sq;
        logic [ACC_W:0]      sum;
        logic [ACC_W-1:0]    best_sum;
        emits = 1'b0;
        result = '0;
        // A count of zero still searches one centroid; larger counts clip.
        n = (count_reg == 0) ? 1 : ((count_reg > CENTROIDS) ? CENTROIDS : count_reg);
        if (w.op == OP_LOAD)
        begin
            codebook[w.csel][w.dsel] = w.value;
            return;
        end
        if (w.dsel < length_reg)
        begin
            for (int c = 0; c < n; c++)
            begin
                d = longint'($signed(w.value)) - longint'($signed(codebook[c][w.dsel]));
                sq = d * d;
                sum = {1'b0, running_sums[c]} + sq[ACC_W:0];
                running_sums[c] = sum[ACC_W] ? ACC_FULL : sum[ACC_W-1:0];
            end
        end
        if (!w.last)
            return;
        best = 0;
        best_sum = running_sums[0];
        for (int c = 1; c < n; c++)
        begin
            if (running_sums[c] < best_sum)
            begin
                best_sum = running_sums[c];
                best = c;
            end
        end
        emits = 1'b1;
        result.cls = best[CLASS_W-1:0];
        result.distance = best_sum;
        for (int c = 0; c < CENTROIDS; c++)
            running_sums[c] = '0;
    endfunction

    // Values lean on the two extremes and on a narrow band around zero, so that
    // equal distances, and with them the tie rule, come up often.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] near_zero;
        near_zero = SAMPLE_W'($urandom_range(0, 6));
        case ($urandom_range(0, 7))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return near_zero - 16'sd3;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic word_t random_word(input logic kind);
        word_t w;
        w.op = kind;
        w.csel = CSEL_W'($urandom);
        w.dsel = DSEL_W'($urandom);
        w.value = pick_sample();
        w.last = 1'($urandom);
        return w;
    endfunction

    function automatic void add_word(input logic o, input logic [CSEL_W-1:0] cs,
                                     input logic [DSEL_W-1:0] ds,
                                     input logic signed [SAMPLE_W-1:0] v, input logic l);
        stimulus_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.word = '{op: o, csel: cs, dsel: ds, value: v, last: l};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_checked(input logic o, input logic [CSEL_W-1:0] cs,
                                        input logic [DSEL_W-1:0] ds,
                                        input logic signed [SAMPLE_W-1:0] v, input logic l,
                                        input logic [CLASS_W-1:0] cls,
                                        input logic [ACC_W-1:0] distance);
        stimulus_row_t row;
        row = '0;
        row.kind = ROW_WORD;
        row.word = '{op: o, csel: cs, dsel: ds, value: v, last: l};
        row.typed = 1'b1;
        row.verdict = '{cls: cls, distance: distance};
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void add_register(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        stimulus_row_t row;
        row = '0;
        row.kind = ROW_REGISTER;
        row.reg_index = idx;
        row.reg_data = data;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic void phase_setting(input int p, output logic [CFG_DATA_W-1:0] count,
                                          output logic [CFG_DATA_W-1:0] length);
        case (p % 10)
            0: begin count = 6'd4;  length = 6'd8;  end
            1: begin count = 6'd16; length = 6'd32; end
            2: begin count = 6'd1;  length = 6'd1;  end
            3: begin count = 6'd9;  length = 6'd5;  end
            4: begin count = 6'd31; length = 6'd3;  end
            5: begin count = 6'd0;  length = 6'd12; end
            6: begin count = 6'd16; length = 6'd63; end
            7: begin count = 6'd2;  length = 6'd0;  end
            8: begin count = 6'd6;  length = 6'd17; end
            default: begin count = 6'd13; length = 6'd2; end
        endcase
    endfunction

    task automatic set_idle(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin sender_idle_pct = 0;        receiver_stall_pct = 0;        end
            IDLE_SENDER:   begin sender_idle_pct = IDLE_PCT; receiver_stall_pct = 0;        end
            IDLE_RECEIVER: begin sender_idle_pct = 0;        receiver_stall_pct = IDLE_PCT; end
            default:       begin sender_idle_pct = BOTH_PCT; receiver_stall_pct = BOTH_PCT; end
        endcase
    endtask

    // Offers one word and returns at the edge that accepts it. Valid stays high
    // on return, so that back-to-back words need no dead cycle; the next call
    // drops it only if it decides to idle first.
    task automatic send_word(input word_t w, input logic typed, input verdict_t typed_verdict);
        logic     emits;
        verdict_t predicted;
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= w.op;
        centroid_sel <= w.csel;
        dim_sel      <= w.dsel;
        sample_value <= w.value;
        last_element <= w.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        classify_word(w, emits, predicted);
        if (emits)
        begin
            vectors_closed++;
            pending_classes = {pending_classes, (typed ? typed_verdict : predicted)};
        end
    endtask

    // Registers change only while the core is quiet. Every result must be back,
    // and a feature word without a last mark may still be in flight, so the
    // task also waits out the core's longest busy time.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_CENTROID_COUNT)
            count_reg = data[CCOUNT_W-1:0];
        else
            length_reg = data[VLEN_W-1:0];
        settings_applied++;
    endtask

    // One random sequence. Most are complete vectors in rotated element order.
    // The rest are load bursts, vectors cut short at positions that may lie past
    // the vector length, and stray feature words.
    task automatic run_sequence();
        word_t       w;
        int unsigned roll;
        int unsigned span;
        int unsigned start;
        roll = $urandom_range(0, 99);
        span = (length_reg == 0) ? 1 : ((length_reg > DIMS) ? DIMS : length_reg);
        if (roll < 65)
        begin
            start = $urandom_range(0, span - 1);
            for (int k = 0; k < span; k++)
            begin
                w = random_word(OP_FEATURE);
                w.dsel = DSEL_W'((start + k) % span);
                w.last = (k == span - 1);
                send_word(w, 1'b0, '0);
            end
        end
        else if (roll < 80)
        begin
            repeat ($urandom_range(1, 8))
                send_word(random_word(OP_LOAD), 1'b0, '0);
        end
        else if (roll < 92)
        begin
            span = $urandom_range(1, span);
            for (int k = 0; k < span; k++)
            begin
                w = random_word(OP_FEATURE);
                w.last = (k == span - 1);
                send_word(w, 1'b0, '0);
            end
        end
        else
        begin
            send_word(random_word(OP_FEATURE), 1'b0, '0);
        end
    endtask

    // The receiver stalls at random, at the rate that the current phase sets.
    always @(posedge clk)
        out_stall <= ($urandom_range(0, 99) < receiver_stall_pct);

    // Every accepted result is checked against the oldest open vector.
    always @(posedge clk)
    begin : check_results
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_classes.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result word with none expected: class %0d distance 0x%010h",
                         $time, class_index, min_distance);
            end
            else
            begin
                want = pending_classes.pop_front();
                results_checked++;
                if (class_index !== want.cls)
                begin
                    mismatch_count++;
                    $display("%0t: class_index expected %0d, got %0d",
                             $time, want.cls, class_index);
                end
                if (min_distance !== want.distance)
                begin
                    mismatch_count++;
                    $display("%0t: min_distance expected 0x%010h, got 0x%010h",
                             $time, want.distance, min_distance);
                end
            end
        end
    end

    initial
    begin : stimulus
        word_t                 w;
        logic [CFG_DATA_W-1:0] count;
        logic [CFG_DATA_W-1:0] length;
        int                    phase;
        int                    random_start;

        for (int c = 0; c < CENTROIDS; c++)
            running_sums[c] = '0;

        // Directed table. The codebook is all zero when it starts, and the
        // registers hold their reset values: fifteen centroids, nineteen elements.
        add_checked(OP_FEATURE, 4'd0,  5'd0,  16'sd0, 1'b1, 4'd0, '0);
        add_checked(OP_FEATURE, 4'hF,  5'd0,  Q_MAX,  1'b1, 4'd0, SQ_OF_Q_MAX);
        add_checked(OP_FEATURE, 4'd7,  5'd18, Q_MIN,  1'b1, 4'd0, SQ_OF_Q_MIN);
        // Past the vector length an element adds nothing but still ends the vector.
        add_checked(OP_FEATURE, 4'd0,  5'd19, Q_MAX,  1'b1, 4'd0, '0);
        // A load ignores its last mark and never answers.
        add_word   (OP_LOAD,    4'd14, 5'd0,  Q_MIN,  1'b1);
        add_checked(OP_FEATURE, 4'hA,  5'd0,  Q_MIN,  1'b1, 4'd14, '0);
        // Centroid 15 sits outside the fifteen in use for now.
        add_word   (OP_LOAD,    4'd15, 5'd0,  Q_MIN,  1'b0);
        add_word   (OP_FEATURE, 4'd3,  5'd0,  Q_MIN,  1'b0);
        add_word   (OP_FEATURE, 4'd3,  5'd1,  16'sh0100, 1'b1);
        // A count change in the middle of a vector governs the following elements.
        add_register(REG_CENTROID_COUNT, 6'd16);
        add_word   (OP_FEATURE, 4'd0,  5'd0,  Q_MIN,  1'b0);
        add_register(REG_CENTROID_COUNT, 6'd0);
        add_word   (OP_FEATURE, 4'd0,  5'd1,  16'sh0001, 1'b1);
        // A count above the table size clips; a zero length adds nothing at all.
        add_register(REG_CENTROID_COUNT, 6'd31);
        add_register(REG_VECTOR_LENGTH, 6'd0);
        add_checked(OP_FEATURE, 4'd0,  5'd0,  Q_MAX,  1'b1, 4'd0, '0);
        add_register(REG_VECTOR_LENGTH, 6'd63);
        add_checked(OP_FEATURE, 4'd0,  5'd31, Q_MAX,  1'b1, 4'd0, SQ_OF_Q_MAX);
        add_word   (OP_LOAD,    4'd15, 5'd31, Q_MAX,  1'b0);
        add_checked(OP_FEATURE, 4'd2,  5'd31, Q_MAX,  1'b1, 4'd15, '0);
        add_word   (OP_FEATURE, 4'd9,  5'd5,  16'sh1234, 1'b0);
        add_word   (OP_FEATURE, 4'd1,  5'd31, Q_MIN,  1'b1);

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The table has no defined content after reset, so every entry is written
        // before any feature word can read it.
        set_idle(IDLE_NONE);
        for (int c = 0; c < CENTROIDS; c++)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                w = '{op: OP_LOAD, csel: CSEL_W'(c), dsel: DSEL_W'(d), value: '0,
                      last: 1'($urandom)};
                send_word(w, 1'b0, '0);
            end
        end

        set_idle(IDLE_BOTH);
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_REGISTER)
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            else
                send_word(directed_rows[i].word, directed_rows[i].typed,
                          directed_rows[i].verdict);
        end

        // Saturation: two centroids at the positive extreme and a vector of
        // negative extremes well over 256 elements long drive both sums to the
        // ceiling. They tie there, so index 0 wins.
        set_idle(IDLE_SENDER);
        write_register(REG_CENTROID_COUNT, 6'd2);
        write_register(REG_VECTOR_LENGTH, 6'd32);
        for (int c = 0; c < 2; c++)
        begin
            for (int d = 0; d < DIMS; d++)
            begin
                w = '{op: OP_LOAD, csel: CSEL_W'(c), dsel: DSEL_W'(d), value: Q_MAX,
                      last: 1'b0};
                send_word(w, 1'b0, '0);
            end
        end
        for (int k = 0; k < OVERFLOW_RUN; k++)
        begin
            w = random_word(OP_FEATURE);
            w.value = Q_MIN;
            w.last = (k == OVERFLOW_RUN - 1);
            send_word(w, 1'b0, '0);
        end

        // Random phases. Each one sets both registers and its own idling pattern.
        random_start = words_sent;
        phase = 0;
        while ((words_sent - random_start) < RANDOM_WORDS)
        begin
            phase_setting(phase, count, length);
            write_register(REG_CENTROID_COUNT, count);
            write_register(REG_VECTOR_LENGTH, length);
            set_idle(idle_mode_e'(phase % 4));
            while ((words_sent - random_start) < (phase + 1) * PHASE_WORDS)
                run_sequence();
            phase++;
        end

        in_valid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);

        $display("Sent %0d words over %0d register writes; %0d vectors closed, %0d checked.",
                 words_sent, settings_applied, vectors_closed, results_checked);
        $display("Covered value extremes, ties, clipped counts, zero length and sum saturation.");
        if (mismatch_count == 0)
            $display("** nearest_centroid_quantizer_core: PASSED **");
        else
            $display("** nearest_centroid_quantizer_core: FAILED **");
        $finish;
    end

    // Hard stop in case the core hangs on either handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timed out with %0d results outstanding", $time, pending_classes.size());
        $display("** nearest_centroid_quantizer_core: FAILED **");
        $finish;
    end

endmodule
